// ===== rtl/uiolc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uiolc_pkg: shared constants for the unicycle I/O linearization controller
// Fixed-point formats, register indexes, reset values and the quarter-wave
// sine table that is built at elaboration.
// ----------------------------------------------------------------------------
package uiolc_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int GAIN_FRAC        = 12;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int FIELD_W = 24;
    localparam int ANGLE_W = 16;
    localparam int DIST_W  = 23;
    localparam int GAIN_W  = 16;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_B     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_OFFSET_B = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_X       = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Y       = 4'd3;

    localparam logic [DIST_W-1:0] OFFSET_B_RST     = 23'd13107;
    localparam logic [DIST_W-1:0] INV_OFFSET_B_RST = 23'd327680;
    localparam logic [GAIN_W-1:0] GAIN_X_RST       = 16'd8192;
    localparam logic [GAIN_W-1:0] GAIN_Y_RST       = 16'd8192;

    // table entries run 0 .. 2^FRAC_BITS, sine/cosine values carry a sign on top
    localparam int SINE_W  = FRAC_BITS + 1;
    localparam int TRIG_W  = FRAC_BITS + 2;
    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int QUAD_W  = ANGLE_W - 2;
    localparam int KPROD_W = QUAD_W + IDX_W;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef logic [SINE_W-1:0] sine_tbl_t [0:SINE_TABLE_DEPTH];

    // one quarter-wave entry, odd Taylor series in Q30 up to x^13
    function automatic logic [SINE_W-1:0] sine_entry(longint unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint          s;
        longint          r;
        x  = (k * HALF_PI_Q30 + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        t  = x;
        s  = longint'(x);
        t  = ((t * x2) >> 30) / 64'd6;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 64'd20;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 64'd42;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 64'd72;
        s  = s + longint'(t);
        t  = ((t * x2) >> 30) / 64'd110;
        s  = s - longint'(t);
        t  = ((t * x2) >> 30) / 64'd156;
        s  = s + longint'(t);
        if (s < 0)
        begin
            s = 0;
        end
        r = (s + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        if (r > (longint'(1) << FRAC_BITS))
        begin
            r = longint'(1) << FRAC_BITS;
        end
        return SINE_W'(r);
    endfunction

    function automatic sine_tbl_t build_sine_tbl();
        sine_tbl_t tbl;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            tbl[k] = sine_entry(longint'(k));
        end
        return tbl;
    endfunction

    localparam sine_tbl_t SINE_TBL = build_sine_tbl();

    // quadrant from the top two bits, mirrored index in odd quadrants
    function automatic logic signed [TRIG_W-1:0] sine_of(logic [ANGLE_W-1:0] a);
        logic [1:0]         quad;
        logic [KPROD_W-1:0] kprod;
        logic [IDX_W-1:0]   k;
        logic [IDX_W-1:0]   idx;
        logic [SINE_W-1:0]  mag;
        quad  = a[ANGLE_W-1 -: 2];
        kprod = KPROD_W'(a[QUAD_W-1:0]) * KPROD_W'(SINE_TABLE_DEPTH);
        k     = kprod[KPROD_W-1:QUAD_W];
        idx   = quad[0] ? (IDX_W'(SINE_TABLE_DEPTH) - k) : k;
        mag   = SINE_TBL[idx];
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

endpackage

// ===== rtl/unicycle_io_linearization_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unicycle_io_linearization_ctrl: offset-point feedback linearization
// Pipelined controller turning pose plus desired offset-point motion into
// saturated forward speed and turn rate commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one pose sample per item:
//   measured x, y, heading and desired offset-point x, y, vx, vy.
//   Output channel (out_valid / out_stall) returns one command item,
//   lin_vel and ang_vel, for every input item, in order.
//   Config channel (cfg_valid / cfg_ready) writes offset_b, inv_offset_b,
//   gain_x, gain_y by index; cfg_ready is always high, unknown indexes are
//   dropped. Write registers only while the pipeline is empty.
//   Throughput is one item per cycle while out_stall is low. The ten
//   stages are: sine/cosine lookup, offset products, point projection,
//   position error, gain products, feedforward sum, rotation products,
//   rotation sums, split reciprocal products and the final round/saturate
//   output register.
//   When out_stall is high, items pile up into empty stages first; in_stall
//   rises only once every stage holds an item. Nothing is lost or repeated.
//   Reset empties the pipeline and loads the default register values.
// ----------------------------------------------------------------------------
module unicycle_io_linearization_ctrl
(
    input  logic                                      clk,
    input  logic                                      rst_n,

    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic signed [uiolc_pkg::FIELD_W-1:0]      meas_x,
    input  logic signed [uiolc_pkg::FIELD_W-1:0]      meas_y,
    input  logic signed [uiolc_pkg::ANGLE_W-1:0]      meas_heading,
    input  logic signed [uiolc_pkg::FIELD_W-1:0]      des_x,
    input  logic signed [uiolc_pkg::FIELD_W-1:0]      des_y,
    input  logic signed [uiolc_pkg::FIELD_W-1:0]      des_vx,
    input  logic signed [uiolc_pkg::FIELD_W-1:0]      des_vy,

    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [uiolc_pkg::FIELD_W-1:0]      lin_vel,
    output logic signed [uiolc_pkg::FIELD_W-1:0]      ang_vel,

    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [uiolc_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [uiolc_pkg::CFG_DATA_W-1:0]          cfg_data
);

    localparam int NS  = 10;
    localparam int FW  = uiolc_pkg::FIELD_W;
    localparam int TW  = uiolc_pkg::TRIG_W;
    localparam int FB  = uiolc_pkg::FRAC_BITS;
    localparam int GF  = uiolc_pkg::GAIN_FRAC;
    localparam int DW  = uiolc_pkg::DIST_W;
    localparam int GW  = uiolc_pkg::GAIN_W;

    // intermediate widths
    localparam int PB_W  = DW + 1 + TW;        // offset * trig
    localparam int PX_W  = FW + 2;             // projected point
    localparam int EX_W  = FW + 3;             // position error
    localparam int PG_W  = GW + 1 + EX_W;      // gain * error
    localparam int UX_W  = PG_W - GF;          // command before rotation
    localparam int PR_W  = TW + UX_W;          // trig * command
    localparam int RS_W  = PR_W + 1;           // sum of two rotation terms
    localparam int RT_W  = RS_W - FB;          // rotated value after rounding
    localparam int LO_W  = 12;                 // low slice of the reciprocal
    localparam int HI_W  = DW - LO_W;
    localparam int PL_W  = RT_W + LO_W + 1;
    localparam int PH_W  = RT_W + HI_W + 1;
    localparam int AT_W  = RT_W + DW + 2;      // full angular product
    localparam int AF_W  = AT_W - FB;
    localparam int SAT_W = AF_W;

    localparam logic signed [PB_W-1:0] RND_PB = PB_W'(1) <<< (FB - 1);
    localparam logic signed [PG_W-1:0] RND_PG = PG_W'(1) <<< (GF - 1);
    localparam logic signed [RS_W-1:0] RND_RS = RS_W'(1) <<< (FB - 1);
    localparam logic signed [AT_W-1:0] RND_AT = AT_W'(1) <<< (FB - 1);

    localparam logic signed [SAT_W-1:0] OUT_MAX = SAT_W'((1 <<< (FW - 1)) - 1);
    localparam logic signed [SAT_W-1:0] OUT_MIN = -SAT_W'(1 <<< (FW - 1));

    function automatic logic signed [FW-1:0] sat_out(logic signed [SAT_W-1:0] v);
        logic signed [FW-1:0] r;
        if (v > OUT_MAX)
        begin
            r = OUT_MAX[FW-1:0];
        end
        else if (v < OUT_MIN)
        begin
            r = OUT_MIN[FW-1:0];
        end
        else
        begin
            r = v[FW-1:0];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [DW-1:0] offset_b_reg;
    logic [DW-1:0] inv_offset_b_reg;
    logic [GW-1:0] gain_x_reg;
    logic [GW-1:0] gain_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_b_reg     <= uiolc_pkg::OFFSET_B_RST;
            inv_offset_b_reg <= uiolc_pkg::INV_OFFSET_B_RST;
            gain_x_reg       <= uiolc_pkg::GAIN_X_RST;
            gain_y_reg       <= uiolc_pkg::GAIN_Y_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                uiolc_pkg::CFG_OFFSET_B:     offset_b_reg     <= cfg_data[DW-1:0];
                uiolc_pkg::CFG_INV_OFFSET_B: inv_offset_b_reg <= cfg_data[DW-1:0];
                uiolc_pkg::CFG_GAIN_X:       gain_x_reg       <= cfg_data[GW-1:0];
                uiolc_pkg::CFG_GAIN_Y:       gain_y_reg       <= cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: a stage moves when empty or when the next one moves
    // ------------------------------------------------------------------
    logic [NS:1] vld_reg;
    logic [NS:1] vld_next;
    logic [NS:1] adv;

    always_comb
    begin
        adv[NS] = !vld_reg[NS] || !out_stall;
        for (int i = NS - 1; i >= 1; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i + 1];
        end
    end

    always_comb
    begin
        vld_next[1] = adv[1] ? in_valid : vld_reg[1];
        for (int i = 2; i <= NS; i++)
        begin
            vld_next[i] = adv[i] ? vld_reg[i - 1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_stall  = !adv[1];
    assign out_valid = vld_reg[NS];

    // ------------------------------------------------------------------
    // stage 1: register the sample, sine and cosine lookup
    // ------------------------------------------------------------------
    logic signed [FW-1:0] s1_mx_reg, s1_my_reg, s1_dx_reg, s1_dy_reg;
    logic signed [FW-1:0] s1_dvx_reg, s1_dvy_reg;
    logic signed [TW-1:0] s1_sn_reg, s1_cs_reg;
    logic signed [TW-1:0] s1_sn_next, s1_cs_next;

    always_comb
    begin
        s1_sn_next = uiolc_pkg::sine_of(meas_heading);
        // cosine is the sine a quarter turn ahead
        s1_cs_next = uiolc_pkg::sine_of(meas_heading + 16'h4000);
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_mx_reg  <= meas_x;
            s1_my_reg  <= meas_y;
            s1_dx_reg  <= des_x;
            s1_dy_reg  <= des_y;
            s1_dvx_reg <= des_vx;
            s1_dvy_reg <= des_vy;
            s1_sn_reg  <= s1_sn_next;
            s1_cs_reg  <= s1_cs_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: offset distance times cos / sin
    // ------------------------------------------------------------------
    logic signed [PB_W-1:0] s2_pbx_reg, s2_pby_reg;
    logic signed [FW-1:0]   s2_mx_reg, s2_my_reg, s2_dx_reg, s2_dy_reg;
    logic signed [FW-1:0]   s2_dvx_reg, s2_dvy_reg;
    logic signed [TW-1:0]   s2_sn_reg, s2_cs_reg;
    logic signed [DW:0]     bb_s;

    assign bb_s = $signed({1'b0, offset_b_reg});

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            s2_pbx_reg <= bb_s * s1_cs_reg;
            s2_pby_reg <= bb_s * s1_sn_reg;
            s2_mx_reg  <= s1_mx_reg;
            s2_my_reg  <= s1_my_reg;
            s2_dx_reg  <= s1_dx_reg;
            s2_dy_reg  <= s1_dy_reg;
            s2_dvx_reg <= s1_dvx_reg;
            s2_dvy_reg <= s1_dvy_reg;
            s2_sn_reg  <= s1_sn_reg;
            s2_cs_reg  <= s1_cs_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: projected point px, py
    // ------------------------------------------------------------------
    logic signed [PB_W-1:0] s3_rx_sum, s3_ry_sum;
    logic signed [PX_W-1:0] s3_px_next, s3_py_next;
    logic signed [PX_W-1:0] s3_px_reg, s3_py_reg;
    logic signed [FW-1:0]   s3_dx_reg, s3_dy_reg, s3_dvx_reg, s3_dvy_reg;
    logic signed [TW-1:0]   s3_sn_reg, s3_cs_reg;

    always_comb
    begin
        s3_rx_sum  = s2_pbx_reg + RND_PB;
        s3_ry_sum  = s2_pby_reg + RND_PB;
        s3_px_next = PX_W'(s2_mx_reg) + $signed(s3_rx_sum[FB +: PX_W]);
        s3_py_next = PX_W'(s2_my_reg) + $signed(s3_ry_sum[FB +: PX_W]);
    end

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            s3_px_reg  <= s3_px_next;
            s3_py_reg  <= s3_py_next;
            s3_dx_reg  <= s2_dx_reg;
            s3_dy_reg  <= s2_dy_reg;
            s3_dvx_reg <= s2_dvx_reg;
            s3_dvy_reg <= s2_dvy_reg;
            s3_sn_reg  <= s2_sn_reg;
            s3_cs_reg  <= s2_cs_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: position error
    // ------------------------------------------------------------------
    logic signed [EX_W-1:0] s4_ex_reg, s4_ey_reg;
    logic signed [FW-1:0]   s4_dvx_reg, s4_dvy_reg;
    logic signed [TW-1:0]   s4_sn_reg, s4_cs_reg;

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            s4_ex_reg  <= EX_W'(s3_dx_reg) - EX_W'(s3_px_reg);
            s4_ey_reg  <= EX_W'(s3_dy_reg) - EX_W'(s3_py_reg);
            s4_dvx_reg <= s3_dvx_reg;
            s4_dvy_reg <= s3_dvy_reg;
            s4_sn_reg  <= s3_sn_reg;
            s4_cs_reg  <= s3_cs_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: gain products
    // ------------------------------------------------------------------
    logic signed [PG_W-1:0] s5_pgx_reg, s5_pgy_reg;
    logic signed [FW-1:0]   s5_dvx_reg, s5_dvy_reg;
    logic signed [TW-1:0]   s5_sn_reg, s5_cs_reg;
    logic signed [GW:0]     gx_s, gy_s;

    assign gx_s = $signed({1'b0, gain_x_reg});
    assign gy_s = $signed({1'b0, gain_y_reg});

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            s5_pgx_reg <= gx_s * s4_ex_reg;
            s5_pgy_reg <= gy_s * s4_ey_reg;
            s5_dvx_reg <= s4_dvx_reg;
            s5_dvy_reg <= s4_dvy_reg;
            s5_sn_reg  <= s4_sn_reg;
            s5_cs_reg  <= s4_cs_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: feedforward plus rounded proportional term
    // ------------------------------------------------------------------
    logic signed [PG_W-1:0] s6_gx_sum, s6_gy_sum;
    logic signed [UX_W-1:0] s6_ux_reg, s6_uy_reg;
    logic signed [TW-1:0]   s6_sn_reg, s6_cs_reg;

    always_comb
    begin
        s6_gx_sum = s5_pgx_reg + RND_PG;
        s6_gy_sum = s5_pgy_reg + RND_PG;
    end

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            s6_ux_reg <= UX_W'(s5_dvx_reg) + $signed(s6_gx_sum[PG_W-1:GF]);
            s6_uy_reg <= UX_W'(s5_dvy_reg) + $signed(s6_gy_sum[PG_W-1:GF]);
            s6_sn_reg <= s5_sn_reg;
            s6_cs_reg <= s5_cs_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 7: rotation products
    // ------------------------------------------------------------------
    logic signed [PR_W-1:0] s7_cux_reg, s7_suy_reg, s7_cuy_reg, s7_sux_reg;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            s7_cux_reg <= s6_cs_reg * s6_ux_reg;
            s7_suy_reg <= s6_sn_reg * s6_uy_reg;
            s7_cuy_reg <= s6_cs_reg * s6_uy_reg;
            s7_sux_reg <= s6_sn_reg * s6_ux_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 8: forward speed (saturated) and rotated lateral term
    // ------------------------------------------------------------------
    logic signed [RS_W-1:0] s8_lin_sum, s8_rot_sum;
    logic signed [FW-1:0]   s8_lin_reg;
    logic signed [RT_W-1:0] s8_rot_reg;

    always_comb
    begin
        s8_lin_sum = RS_W'(s7_cux_reg) + RS_W'(s7_suy_reg) + RND_RS;
        s8_rot_sum = RS_W'(s7_cuy_reg) - RS_W'(s7_sux_reg) + RND_RS;
    end

    always_ff @(posedge clk)
    begin
        if (adv[8])
        begin
            s8_lin_reg <= sat_out(SAT_W'($signed(s8_lin_sum[RS_W-1:FB])));
            s8_rot_reg <= $signed(s8_rot_sum[RS_W-1:FB]);
        end
    end

    // ------------------------------------------------------------------
    // stage 9: reciprocal product, split in two slices
    // ------------------------------------------------------------------
    logic signed [PL_W-1:0] s9_plo_reg;
    logic signed [PH_W-1:0] s9_phi_reg;
    logic signed [FW-1:0]   s9_lin_reg;
    logic signed [LO_W:0]   inv_lo_s;
    logic signed [HI_W:0]   inv_hi_s;

    assign inv_lo_s = $signed({1'b0, inv_offset_b_reg[LO_W-1:0]});
    assign inv_hi_s = $signed({1'b0, inv_offset_b_reg[DW-1:LO_W]});

    always_ff @(posedge clk)
    begin
        if (adv[9])
        begin
            s9_plo_reg <= s8_rot_reg * inv_lo_s;
            s9_phi_reg <= s8_rot_reg * inv_hi_s;
            s9_lin_reg <= s8_lin_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 10: recombine, round, saturate; output register
    // ------------------------------------------------------------------
    logic signed [AT_W-1:0] s10_tot;
    logic signed [FW-1:0]   s10_lin_reg, s10_ang_reg;

    always_comb
    begin
        s10_tot = (AT_W'(s9_phi_reg) <<< LO_W) + AT_W'(s9_plo_reg) + RND_AT;
    end

    always_ff @(posedge clk)
    begin
        if (adv[10])
        begin
            s10_lin_reg <= s9_lin_reg;
            s10_ang_reg <= sat_out($signed(s10_tot[AT_W-1:FB]));
        end
    end

    assign lin_vel = s10_lin_reg;
    assign ang_vel = s10_ang_reg;

endmodule
